/* rtl/dstg_pkg.sv */
`default_nettype none
package dstg_pkg;

   localparam int SINE_BITS   = 15;
   localparam int ENV_BITS    = 31;
   localparam int ENV_FRAC    = 16;
   localparam int AMP_BITS    = 15;
   localparam int DECAY_BITS  = 16;
   localparam int SAMPLE_BITS = 16;
   localparam int DATA_BITS   = 32;
   localparam int ADDR_BITS   = 4;

   // pi/2 in Q2.30
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic signed [63:0] FULL_SCALE = 64'sd32767;

   typedef enum logic [1:0] {
      CSR_PHASE_STEP   = 2'd0,
      CSR_TONE_LENGTH  = 2'd1,
      CSR_AMPLITUDE    = 2'd2,
      CSR_DECAY_FACTOR = 2'd3
   } csr_reg_type;

   // one sample between the oscillator stage and the output multiply
   typedef struct packed {
      logic [SINE_BITS-1:0] sine_mag;
      logic                 sine_neg;
      logic [ENV_BITS-1:0]  env;
      logic                 active;
      logic                 last;
   } stage_type;

   // Q0.15 sine of x (Q2.30 radians, 0..pi/2), Taylor series to x^15.
   // Elaboration-time only: every call has a constant argument.
   function automatic logic [SINE_BITS-1:0] dstg_sine_entry(input logic [63:0] x);
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic signed [63:0] v;
      term = x;
      sum  = $signed(x);
      term = ((term * x) >> 30) / 64'd6;   term = (term * x) >> 30; sum = sum - $signed(term);
      term = ((term * x) >> 30) / 64'd20;  term = (term * x) >> 30; sum = sum + $signed(term);
      term = ((term * x) >> 30) / 64'd42;  term = (term * x) >> 30; sum = sum - $signed(term);
      term = ((term * x) >> 30) / 64'd72;  term = (term * x) >> 30; sum = sum + $signed(term);
      term = ((term * x) >> 30) / 64'd110; term = (term * x) >> 30; sum = sum - $signed(term);
      term = ((term * x) >> 30) / 64'd156; term = (term * x) >> 30; sum = sum + $signed(term);
      term = ((term * x) >> 30) / 64'd210; term = (term * x) >> 30; sum = sum - $signed(term);
      if (sum < 0) begin
         sum = '0;
      end
      v = (sum * FULL_SCALE + (64'sd1 <<< 29)) >>> 30;
      if (v > FULL_SCALE) begin
         v = FULL_SCALE;
      end
      return v[SINE_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

/* rtl/dstg_if.sv */
`default_nettype none
interface dstg_req_if;
   logic valid;
   logic ready;
   logic start_req;

   modport source (output valid, output start_req, input ready);
   modport sink   (input valid, input start_req, output ready);
endinterface

interface dstg_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [15:0]  sample;
   logic                active;
   logic                last;

   modport source (output valid, output sample, output active, output last, input ready);
   modport sink   (input valid, input sample, input active, input last, output ready);
endinterface
`default_nettype wire

/* rtl/dstg_csr.sv */
`default_nettype none
module dstg_csr
   import dstg_pkg::*;
#(
   parameter int PHASE_BITS  = 24,
   parameter int LENGTH_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [ADDR_BITS-1:0]   paddr,
   input  wire logic [DATA_BITS-1:0]   pwdata,
   output logic      [DATA_BITS-1:0]   prdata,
   output logic                        pready,
   output logic      [PHASE_BITS-1:0]  phase_step,
   output logic      [LENGTH_BITS-1:0] tone_length,
   output logic      [AMP_BITS-1:0]    amplitude,
   output logic      [DECAY_BITS-1:0]  decay_factor
);

   logic [PHASE_BITS-1:0]  phase_step_ff,   phase_step_in;
   logic [LENGTH_BITS-1:0] tone_length_ff,  tone_length_in;
   logic [AMP_BITS-1:0]    amplitude_ff,    amplitude_in;
   logic [DECAY_BITS-1:0]  decay_factor_ff, decay_factor_in;
   logic                   wr_en;
   csr_reg_type            reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_sel = csr_reg_type'(paddr[3:2]);

   always_comb begin
      phase_step_in   = phase_step_ff;
      tone_length_in  = tone_length_ff;
      amplitude_in    = amplitude_ff;
      decay_factor_in = decay_factor_ff;
      prdata          = '0;
      unique case (reg_sel)
         CSR_PHASE_STEP: begin
            prdata = DATA_BITS'(phase_step_ff);
            if (wr_en) phase_step_in = pwdata[PHASE_BITS-1:0];
         end
         CSR_TONE_LENGTH: begin
            prdata = DATA_BITS'(tone_length_ff);
            if (wr_en) tone_length_in = pwdata[LENGTH_BITS-1:0];
         end
         CSR_AMPLITUDE: begin
            prdata = DATA_BITS'(amplitude_ff);
            if (wr_en) amplitude_in = pwdata[AMP_BITS-1:0];
         end
         CSR_DECAY_FACTOR: begin
            prdata = DATA_BITS'(decay_factor_ff);
            if (wr_en) decay_factor_in = pwdata[DECAY_BITS-1:0];
         end
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff   <= '0;
         tone_length_ff  <= '0;
         amplitude_ff    <= '0;
         decay_factor_ff <= '1;
      end else begin
         phase_step_ff   <= phase_step_in;
         tone_length_ff  <= tone_length_in;
         amplitude_ff    <= amplitude_in;
         decay_factor_ff <= decay_factor_in;
      end
   end

   assign phase_step   = phase_step_ff;
   assign tone_length  = tone_length_ff;
   assign amplitude    = amplitude_ff;
   assign decay_factor = decay_factor_ff;

endmodule
`default_nettype wire

/* rtl/dstg_sine_lut.sv */
`default_nettype none
module dstg_sine_lut
   import dstg_pkg::*;
#(
   parameter int PHASE_BITS       = 24,
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  wire logic [PHASE_BITS-1:0] phase,
   output logic      [SINE_BITS-1:0]  sine_mag,
   output logic                       sine_neg
);

   localparam int QUAD_BITS = PHASE_BITS - 2;
   localparam int IDX_BITS  = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int PROD_BITS = QUAD_BITS + IDX_BITS;

   logic [SINE_BITS-1:0] quarter_rom [0:SINE_TABLE_DEPTH];
   logic [1:0]           quad;
   logic [PROD_BITS-1:0] scaled;
   logic [IDX_BITS-1:0]  idx;
   logic [IDX_BITS-1:0]  rom_addr;

   // quarter-wave table, entries 0..DEPTH inclusive
   for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
      localparam logic [63:0] X = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
      assign quarter_rom[k] = dstg_sine_entry(X);
   end

   always_comb begin
      quad   = phase[PHASE_BITS-1 -: 2];
      scaled = PROD_BITS'(phase[QUAD_BITS-1:0]) * PROD_BITS'(SINE_TABLE_DEPTH);
      idx    = scaled[QUAD_BITS +: IDX_BITS];
      // odd quadrants run the table backward
      rom_addr = quad[0] ? IDX_BITS'(SINE_TABLE_DEPTH) - idx : idx;
      sine_mag = quarter_rom[rom_addr];
      sine_neg = quad[1];
   end

endmodule
`default_nettype wire

/* rtl/dstg_osc.sv */
`default_nettype none
module dstg_osc
   import dstg_pkg::*;
#(
   parameter int PHASE_BITS       = 24,
   parameter int SINE_TABLE_DEPTH = 256,
   parameter int LENGTH_BITS      = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire logic                   start_req,
   input  wire logic                   advance,
   input  wire logic [PHASE_BITS-1:0]  phase_step,
   input  wire logic [LENGTH_BITS-1:0] tone_length,
   input  wire logic [AMP_BITS-1:0]    amplitude,
   input  wire logic [DECAY_BITS-1:0]  decay_factor,
   output stage_type                   stage,
   output logic                        stage_valid
);

   logic [PHASE_BITS-1:0]          phase_ff,   phase_in;
   logic [ENV_BITS-1:0]            env_ff,     env_in;
   logic [LENGTH_BITS-1:0]         idx_ff,     idx_in;
   logic                           playing_ff, playing_in;
   logic                           valid_ff,   valid_in;
   stage_type                      stage_ff,   stage_in;

   logic [PHASE_BITS-1:0]          cur_phase;
   logic [ENV_BITS-1:0]            cur_env;
   logic [LENGTH_BITS-1:0]         cur_idx;
   logic                           cur_play;
   logic [LENGTH_BITS:0]           idx_inc;
   logic                           is_last;
   logic [ENV_BITS+DECAY_BITS-1:0] env_prod;
   logic [SINE_BITS-1:0]           lut_mag;
   logic                           lut_neg;

   dstg_sine_lut #(
      .PHASE_BITS       (PHASE_BITS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_lut (
      .phase    (cur_phase),
      .sine_mag (lut_mag),
      .sine_neg (lut_neg)
   );

   always_comb begin
      // a start overrides the running tone on this very tick
      cur_phase = start_req ? '0 : phase_ff;
      cur_env   = start_req ? {amplitude, ENV_FRAC'(0)} : env_ff;
      cur_idx   = start_req ? '0 : idx_ff;
      cur_play  = start_req ? (tone_length != '0) : playing_ff;

      idx_inc  = {1'b0, cur_idx} + (LENGTH_BITS+1)'(1);
      is_last  = idx_inc >= {1'b0, tone_length};
      env_prod = (ENV_BITS+DECAY_BITS)'(cur_env) * (ENV_BITS+DECAY_BITS)'(decay_factor);

      phase_in   = phase_ff;
      env_in     = env_ff;
      idx_in     = idx_ff;
      playing_in = playing_ff;
      stage_in   = stage_ff;
      if (accept) begin
         phase_in   = cur_play ? cur_phase + phase_step : cur_phase;
         env_in     = cur_play ? env_prod[ENV_FRAC +: ENV_BITS] : cur_env;
         idx_in     = cur_play ? idx_inc[LENGTH_BITS-1:0] : cur_idx;
         playing_in = cur_play && !is_last;

         stage_in.sine_mag = cur_play ? lut_mag : '0;
         stage_in.sine_neg = cur_play && lut_neg;
         stage_in.env      = cur_env;
         stage_in.active   = cur_play;
         stage_in.last     = cur_play && is_last;
      end

      priority if (accept) valid_in = 1'b1;
      else if (advance)    valid_in = 1'b0;
      else                 valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         env_ff     <= '0;
         idx_ff     <= '0;
         playing_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         env_ff     <= env_in;
         idx_ff     <= idx_in;
         playing_ff <= playing_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign stage       = stage_ff;
   assign stage_valid = valid_ff;

endmodule
`default_nettype wire

/* rtl/dstg_shaper.sv */
`default_nettype none
module dstg_shaper
   import dstg_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire stage_type stage,
   input  wire logic    stage_valid,
   output logic         take,
   dstg_rsp_if.source   rsp
);

   localparam int PROD_BITS = SINE_BITS + ENV_BITS;

   logic [PROD_BITS-1:0]          prod;
   logic [SINE_BITS-1:0]          mag;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                          active_ff, active_in;
   logic                          last_ff,   last_in;
   logic                          valid_ff,  valid_in;

   assign take = !valid_ff || rsp.ready;

   always_comb begin
      prod = PROD_BITS'(stage.sine_mag) * PROD_BITS'(stage.env);
      // top bits of a 15 x 31 product never exceed full scale
      mag  = prod[PROD_BITS-1 -: SINE_BITS];

      sample_in = sample_ff;
      active_in = active_ff;
      last_in   = last_ff;
      valid_in  = valid_ff;
      if (take) begin
         valid_in  = stage_valid;
         sample_in = stage.sine_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
         active_in = stage.active;
         last_in   = stage.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      active_ff <= active_in;
      last_ff   <= last_in;
   end

   assign rsp.valid  = valid_ff;
   assign rsp.sample = sample_ff;
   assign rsp.active = active_ff;
   assign rsp.last   = last_ff;

endmodule
`default_nettype wire

/* rtl/damped_sine_tone_generator_top.sv */
// Path: an accepted item is registered first in the oscillator stage register,
//   then in the output register, which drives the sample on rsp.
// Throughput: one item per clock while rsp takes samples; the oscillator stage
//   and the output multiply advance whenever the output slot frees.
// Reset (synchronous, active high): tone idle, phase/envelope/index cleared,
//   registers to phase_step 0, tone_length 0, amplitude 0, decay_factor 0xFFFF.
`default_nettype none
module damped_sine_tone_generator_top
   import dstg_pkg::*;
#(
   parameter int PHASE_BITS       = 24,
   parameter int SINE_TABLE_DEPTH = 256,
   parameter int LENGTH_BITS      = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [ADDR_BITS-1:0] paddr,
   input  wire logic [DATA_BITS-1:0] pwdata,
   output logic      [DATA_BITS-1:0] prdata,
   output logic                      pready,
   dstg_req_if.sink                  req_chan,
   dstg_rsp_if.source                rsp_chan
);

   logic [PHASE_BITS-1:0]  phase_step;
   logic [LENGTH_BITS-1:0] tone_length;
   logic [AMP_BITS-1:0]    amplitude;
   logic [DECAY_BITS-1:0]  decay_factor;
   stage_type              stage;
   logic                   stage_valid;
   logic                   take;
   logic                   accept;

   // Configuration registers: amplitude is only sampled on a start, the rest
   // act on the very next item.
   dstg_csr #(
      .PHASE_BITS  (PHASE_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .phase_step   (phase_step),
      .tone_length  (tone_length),
      .amplitude    (amplitude),
      .decay_factor (decay_factor)
   );

   // The stage register accepts a new item when empty or when its item moves
   // on into the output register in the same cycle.
   assign req_chan.ready = !stage_valid || take;
   assign accept         = req_chan.valid && req_chan.ready;

   // Stage 1: apply start, look up sine, step phase/index, decay the envelope.
   dstg_osc #(
      .PHASE_BITS       (PHASE_BITS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .LENGTH_BITS      (LENGTH_BITS)
   ) u_osc (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .start_req    (req_chan.start_req),
      .advance      (take),
      .phase_step   (phase_step),
      .tone_length  (tone_length),
      .amplitude    (amplitude),
      .decay_factor (decay_factor),
      .stage        (stage),
      .stage_valid  (stage_valid)
   );

   // Stage 2: scale sine by envelope, sign it, hold it until rsp takes it.
   dstg_shaper u_shaper (
      .clock       (clock),
      .reset       (reset),
      .stage       (stage),
      .stage_valid (stage_valid),
      .take        (take),
      .rsp         (rsp_chan)
   );

   // The final sample of a tone always belongs to a playing tone.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.last |-> rsp_chan.active)
      else $error("last flagged on an idle sample");

   // Idle ticks produce silence.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.active |-> rsp_chan.sample == 16'sd0)
      else $error("nonzero sample while no tone plays");

   // The 15-bit magnitude keeps the sample within full scale in both directions.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.sample != 16'sh8000)
      else $error("sample outside +-32767");

   // An empty pipeline never refuses an item.
   assert property (@(posedge clock) disable iff (reset)
      !stage_valid && !rsp_chan.valid |-> req_chan.ready)
      else $error("ready low with both stages empty");

endmodule
`default_nettype wire
